[rtl/tracker_channel_effect_engine_top_macros.svh]
// Assertion macros for the channel effect engine.
`ifndef TRACKER_CHANNEL_EFFECT_ENGINE_TOP_MACROS_SVH
`define TRACKER_CHANNEL_EFFECT_ENGINE_TOP_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define TCE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that applies only while a result beat is on offer.
`define TCE_CHECK_OUT(lbl, prop, msg) \
  `TCE_CHECK(lbl, out_valid |-> (prop), msg)

`endif

[rtl/tce_pkg.sv]
// ----------------------------------------------------------------------------
// tce_pkg
// Types, effect codes and tables for the tracker channel effect engine.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int CHANNELS_DEF = 4;

  // effect numbers
  localparam logic [3:0] EFF_SPEED   = 4'd1;
  localparam logic [3:0] EFF_JUMP    = 4'd2;
  localparam logic [3:0] EFF_BREAK   = 4'd3;
  localparam logic [3:0] EFF_VOLSLD  = 4'd4;
  localparam logic [3:0] EFF_SLDDN   = 4'd5;
  localparam logic [3:0] EFF_SLDUP   = 4'd6;
  localparam logic [3:0] EFF_PORTA   = 4'd7;
  localparam logic [3:0] EFF_VIBRATO = 4'd8;
  localparam logic [3:0] EFF_TREMOR  = 4'd9;
  localparam logic [3:0] EFF_ARP     = 4'd10;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [6:0] VOL_MAX    = 7'd64;
  localparam logic [7:0] SLIDE_SKIP = 8'hE0;

  localparam logic [7:0] SINE [32] = '{
    8'd0, 8'd24, 8'd49, 8'd74, 8'd97, 8'd120, 8'd141, 8'd161,
    8'd180, 8'd197, 8'd212, 8'd224, 8'd235, 8'd244, 8'd250, 8'd253,
    8'd255, 8'd253, 8'd250, 8'd244, 8'd235, 8'd224, 8'd212, 8'd197,
    8'd180, 8'd161, 8'd141, 8'd120, 8'd97, 8'd74, 8'd49, 8'd24
  };

  // Q16 semitone ratios 2^(-n/12)
  localparam logic [16:0] SEMI [16] = '{
    17'd65536, 17'd61858, 17'd58386, 17'd55109, 17'd52016, 17'd49097, 17'd46341,
    17'd43740, 17'd41285, 17'd38968, 17'd36781, 17'd34716, 17'd32768, 17'd30929,
    17'd29193, 17'd27554
  };

  // tick modulo three
  localparam logic [1:0] MOD3 [32] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
  };

  // per-channel record
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] dest;
    logic [6:0]  vol;
    logic [6:0]  gate;
    logic [7:0]  last_vs;
    logic [7:0]  last_sl;
    logic [7:0]  last_po;
    logic [3:0]  vib_spd;
    logic [3:0]  vib_dep;
    logic [5:0]  vib_pos;
    logic [7:0]  trem_prm;
    logic [5:0]  trem_cnt;
  } rec_t;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  chan;
    logic [4:0]  tick;
    logic [3:0]  code;
    logic [7:0]  prm;
    logic [15:0] new_period;
    logic [15:0] target;
    logic [6:0]  new_vol;
    logic        ld_period;
    logic        ld_target;
    logic        ld_vol;
    logic [7:0]  order_now;
  } item_t;

  typedef struct packed {
    logic [1:0]  chan;
    logic        freq_upd;
    logic [15:0] period;
    logic [6:0]  vol;
    logic [6:0]  gain;
    logic        speed_upd;
    logic [3:0]  speed;
    logic        jump_upd;
    logic [7:0]  jump_ord;
    logic        brk_upd;
    logic [7:0]  brk_row;
  } res_t;

endpackage

[rtl/tracker_channel_effect_engine_top.sv]
// ----------------------------------------------------------------------------
// tracker_channel_effect_engine_top
// Per-channel tick engine for a tracker: row loads and effects A to J.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_ready is high and offers one result beat
// per input beat, through the stage register s1 and then the result register.
// Each beat reads its channel's record from the channel record memory when
// accepted and writes it back when it leaves s1, one read and one write per
// cycle; a back-to-back beat on the same channel takes the fresh record from a
// forward path. The result register lets a new beat in while a result waits.
// Reset clears the per-entry valid bits at once, so no clearing pass is run.
// ----------------------------------------------------------------------------
`include "tracker_channel_effect_engine_top_macros.svh"

module tracker_channel_effect_engine_top #(
  parameter int CHANNELS = tce_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [1:0]  in_chan,
  input  logic [4:0]  in_tick_number,
  input  logic [3:0]  in_effect_code,
  input  logic [7:0]  in_effect_param,
  input  logic [15:0] in_new_period,
  input  logic [15:0] in_target_period,
  input  logic [6:0]  in_new_volume,
  input  logic        in_load_period,
  input  logic        in_load_target,
  input  logic        in_load_volume,
  input  logic [7:0]  in_order_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_chan,
  output logic        out_freq_update,
  output logic [15:0] out_play_period,
  output logic [6:0]  out_chan_volume,
  output logic [6:0]  out_master_gain,
  output logic        out_speed_update,
  output logic [3:0]  out_new_speed,
  output logic        out_jump_update,
  output logic [7:0]  out_jump_order,
  output logic        out_break_update,
  output logic [7:0]  out_break_row
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic           loop_en_r;
  logic           s1_v_r;
  tce_pkg::item_t s1_item_r;
  logic           s1_ok_r;
  logic           fwd_sel_r;
  tce_pkg::rec_t  fwd_rec_r;
  logic           out_v_r;
  tce_pkg::res_t  out_r;

  tce_pkg::item_t in_item;
  tce_pkg::rec_t  mem_rd, cur_rec, new_rec;
  tce_pkg::res_t  res;
  logic           adv, accept, commit, in_ok, hit;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      loop_en_r <= cfg_wr_data;
    end
  end

  // input beat
  always_comb begin
    in_item.opcode     = in_opcode;
    in_item.chan       = in_chan;
    in_item.tick       = in_tick_number;
    in_item.code       = in_effect_code;
    in_item.prm        = in_effect_param;
    in_item.new_period = in_new_period;
    in_item.target     = in_target_period;
    in_item.new_vol    = in_new_volume;
    in_item.ld_period  = in_load_period;
    in_item.ld_target  = in_load_target;
    in_item.ld_vol     = in_load_volume;
    in_item.order_now  = in_order_now;
  end

  // handshake
  assign adv      = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || adv;
  assign accept   = in_valid && in_ready;
  assign commit   = s1_v_r && adv;
  assign in_ok    = (32'(in_chan) < CHANNELS);
  assign hit      = commit && s1_ok_r && (s1_item_r.chan == in_chan);

  tce_rec_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && in_ok),
    .rd_addr (AW'(in_chan)),
    .rd_data (mem_rd),
    .wr_en   (commit && s1_ok_r),
    .wr_addr (AW'(s1_item_r.chan)),
    .wr_data (new_rec)
  );

  // forward a record written in the read cycle
  assign cur_rec = fwd_sel_r ? fwd_rec_r : mem_rd;

  tce_fx u_fx (
    .item    (s1_item_r),
    .rec     (cur_rec),
    .loop_en (loop_en_r),
    .chan_ok (s1_ok_r),
    .rec_nxt (new_rec),
    .res     (res)
  );

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (commit) begin
        s1_v_r <= 1'b0;
      end
      if (commit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
      s1_ok_r   <= in_ok;
      fwd_sel_r <= hit;
      fwd_rec_r <= new_rec;
    end
    if (commit) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_chan         = out_r.chan;
  assign out_freq_update  = out_r.freq_upd;
  assign out_play_period  = out_r.period;
  assign out_chan_volume  = out_r.vol;
  assign out_master_gain  = out_r.gain;
  assign out_speed_update = out_r.speed_upd;
  assign out_new_speed    = out_r.speed;
  assign out_jump_update  = out_r.jump_upd;
  assign out_jump_order   = out_r.jump_ord;
  assign out_break_update = out_r.brk_upd;
  assign out_break_row    = out_r.brk_row;

  // checks
  `TCE_CHECK(a_one_result, commit |=> out_valid, "result beat missing after commit")
  `TCE_CHECK_OUT(a_gain, out_master_gain == 7'd0 || out_master_gain == 7'd64, "bad gain")
  `TCE_CHECK_OUT(a_vol, out_chan_volume <= 7'd64, "volume above 64")
  `TCE_CHECK_OUT(a_jump, !out_jump_update || (out_break_update && out_break_row == 8'd0), "jump without break")

endmodule

[rtl/tce_rec_mem.sv]
// ----------------------------------------------------------------------------
// tce_rec_mem
// Channel record store: one write and one registered read per cycle, with
// per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module tce_rec_mem #(
  parameter int CHANNELS = tce_pkg::CHANNELS_DEF,
  parameter int AW       = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output tce_pkg::rec_t      rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  tce_pkg::rec_t      wr_data
);

  tce_pkg::rec_t        mem [CHANNELS];
  tce_pkg::rec_t        rdata_r;
  logic                 rvld_r;
  logic [CHANNELS-1:0]  vld_r;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

[rtl/tce_fx.sv]
// ----------------------------------------------------------------------------
// tce_fx
// Effect unit: from one channel record and one beat, the updated record and
// the result beat.
// ----------------------------------------------------------------------------
module tce_fx (
  input  tce_pkg::item_t  item,
  input  tce_pkg::rec_t   rec,
  input  logic            loop_en,
  input  logic            chan_ok,
  output tce_pkg::rec_t   rec_nxt,
  output tce_pkg::res_t   res
);

  logic [3:0]  px, py;
  logic        t0;
  logic [9:0]  sl_d, po_d;
  logic [15:0] diff_dn, diff_up;
  logic [11:0] vib_prod;
  logic [6:0]  vib_delta;
  logic [7:0]  tprm;
  logic [4:0]  on_n, off_n;
  logic [5:0]  on_off;
  logic [6:0]  cnt1;
  logic [3:0]  semi_n;
  logic [32:0] arp_prod;
  logic [6:0]  vs_add;

  assign px = item.prm[7:4];
  assign py = item.prm[3:0];
  assign t0 = (item.tick == 5'd0);

  // arithmetic used by the effect branches
  assign sl_d      = {rec.last_sl, 2'b00};
  assign po_d      = {rec.last_po, 2'b00};
  assign diff_dn   = rec.period - rec.dest;
  assign diff_up   = rec.dest - rec.period;
  assign vib_prod  = tce_pkg::SINE[rec.vib_pos[4:0]] * rec.vib_dep;
  assign vib_delta = vib_prod[11:5];
  assign tprm      = (t0 && item.prm != 8'd0) ? item.prm : rec.trem_prm;
  assign on_n      = {1'b0, tprm[7:4]} + 5'd1;
  assign off_n     = {1'b0, tprm[3:0]} + 5'd1;
  assign on_off    = {1'b0, on_n} + {1'b0, off_n};
  assign cnt1      = {1'b0, rec.trem_cnt} + 7'd1;
  assign vs_add    = rec.vol + {3'b000, rec.last_vs[7:4]};
  assign semi_n    = (tce_pkg::MOD3[item.tick] == 2'd1) ? px :
                     (tce_pkg::MOD3[item.tick] == 2'd2) ? py : 4'd0;
  assign arp_prod  = rec.period * tce_pkg::SEMI[semi_n];

  always_comb begin
    rec_nxt = rec;
    res     = '0;
    res.chan = item.chan;
    if (item.opcode == tce_pkg::OP_LOAD) begin
      // row load
      if (item.ld_vol) begin
        rec_nxt.vol = (item.new_vol > tce_pkg::VOL_MAX) ? tce_pkg::VOL_MAX : item.new_vol;
      end
      if (item.ld_target) begin
        rec_nxt.dest = item.target;
      end
      if (item.ld_period) begin
        rec_nxt.period = item.new_period;
        res.freq_upd   = 1'b1;
        res.period     = item.new_period;
      end
      rec_nxt.gate = tce_pkg::VOL_MAX;
    end else begin
      case (item.code)
        tce_pkg::EFF_SPEED: begin
          if (t0) begin
            res.speed_upd = 1'b1;
            res.speed     = px;
          end
        end
        tce_pkg::EFF_JUMP: begin
          if (t0 && !(item.prm < item.order_now && !loop_en)) begin
            res.jump_upd = 1'b1;
            res.jump_ord = item.prm;
            res.brk_upd  = 1'b1;
          end
        end
        tce_pkg::EFF_BREAK: begin
          if (t0) begin
            res.brk_upd = 1'b1;
            res.brk_row = ({4'd0, px} * 8'd10) + {4'd0, py};
          end
        end
        tce_pkg::EFF_VOLSLD: begin
          if (t0) begin
            if (item.prm != 8'd0) rec_nxt.last_vs = item.prm;
          end else if (rec.last_vs[3:0] == 4'd0) begin
            rec_nxt.vol = (vs_add > tce_pkg::VOL_MAX) ? tce_pkg::VOL_MAX : vs_add;
          end else if (rec.last_vs[7:4] == 4'd0) begin
            rec_nxt.vol = (rec.vol > {3'b000, rec.last_vs[3:0]}) ?
                          rec.vol - {3'b000, rec.last_vs[3:0]} : 7'd0;
          end
        end
        tce_pkg::EFF_SLDDN, tce_pkg::EFF_SLDUP: begin
          if (t0) begin
            if (item.prm != 8'd0) rec_nxt.last_sl = item.prm;
          end else if (rec.last_sl < tce_pkg::SLIDE_SKIP) begin
            rec_nxt.period = (item.code == tce_pkg::EFF_SLDDN) ?
                             rec.period + {6'd0, sl_d} : rec.period - {6'd0, sl_d};
            res.freq_upd   = 1'b1;
            res.period     = rec_nxt.period;
          end
        end
        tce_pkg::EFF_PORTA: begin
          if (t0) begin
            if (item.prm != 8'd0) rec_nxt.last_po = item.prm;
          end else if (rec.dest != 16'd0) begin
            if (rec.period > rec.dest) begin
              rec_nxt.period = (diff_dn > {6'd0, po_d}) ? rec.period - {6'd0, po_d} : rec.dest;
            end else if (rec.period < rec.dest) begin
              rec_nxt.period = (diff_up > {6'd0, po_d}) ? rec.period + {6'd0, po_d} : rec.dest;
            end
            res.freq_upd = 1'b1;
            res.period   = rec_nxt.period;
          end
        end
        tce_pkg::EFF_VIBRATO: begin
          if (t0) begin
            rec_nxt.vib_pos = 6'd0;
            if (px != 4'd0) rec_nxt.vib_spd = px;
            if (py != 4'd0) rec_nxt.vib_dep = py;
          end else begin
            res.freq_upd    = 1'b1;
            res.period      = rec.vib_pos[5] ? rec.period - {9'd0, vib_delta} :
                                               rec.period + {9'd0, vib_delta};
            rec_nxt.vib_pos = rec.vib_pos + {2'b00, rec.vib_spd};
          end
        end
        tce_pkg::EFF_TREMOR: begin
          rec_nxt.trem_prm = tprm;
          rec_nxt.gate     = ({1'b0, rec.trem_cnt} < {2'b00, on_n}) ? tce_pkg::VOL_MAX : 7'd0;
          rec_nxt.trem_cnt = (cnt1 > {1'b0, on_off}) ? 6'd0 : cnt1[5:0];
        end
        tce_pkg::EFF_ARP: begin
          if (item.prm != 8'd0 && rec.period != 16'd0) begin
            res.freq_upd = 1'b1;
            res.period   = arp_prod[31:16];
          end
        end
        default: begin
        end
      endcase
    end
    res.vol  = rec_nxt.vol;
    res.gain = rec_nxt.gate;
    // channel outside the configured set: no effect, blank result
    if (!chan_ok) begin
      rec_nxt  = rec;
      res      = '0;
      res.chan = item.chan;
    end
  end

endmodule
